### rtl/salsa20_stream_xor_core_defines.svh
// Assertion macros shared by the Salsa20 stream XOR RTL.
`ifndef SALSA20_STREAM_XOR_CORE_DEFINES_SVH
`define SALSA20_STREAM_XOR_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define S20SX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define S20SX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/s20sx_pkg.sv
// Types, constants and helper functions for the Salsa20 stream XOR block.
package s20sx_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646E;
  localparam logic [31:0] SIGMA2 = 32'h79622D32;
  localparam logic [31:0] SIGMA3 = 32'h6B206574;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY01  = 3'd0;
  localparam logic [2:0] CFG_KEY23  = 3'd1;
  localparam logic [2:0] CFG_KEY45  = 3'd2;
  localparam logic [2:0] CFG_KEY67  = 3'd3;
  localparam logic [2:0] CFG_NONCE  = 3'd4;
  localparam logic [2:0] CFG_ROUNDS = 3'd5;

  localparam logic [4:0] ROUNDS_RESET = 5'd20;

  typedef enum logic [2:0] {
    ROT_0,
    ROT_7,
    ROT_9,
    ROT_13,
    ROT_18
  } s20sx_rot_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINAL
  } s20sx_core_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_GEN,
    TOP_EMIT
  } s20sx_top_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } s20sx_core_status_t;

  // Word idx of the initial Salsa20 state matrix.
  function automatic logic [31:0] init_word(
    input logic [3:0]  idx,
    input logic [63:0] k01,
    input logic [63:0] k23,
    input logic [63:0] k45,
    input logic [63:0] k67,
    input logic [63:0] nonce_v,
    input logic [63:0] ctr
  );
    logic [31:0] w;
    case (idx)
      4'd0:    w = SIGMA0;
      4'd1:    w = k01[31:0];
      4'd2:    w = k01[63:32];
      4'd3:    w = k23[31:0];
      4'd4:    w = k23[63:32];
      4'd5:    w = SIGMA1;
      4'd6:    w = nonce_v[31:0];
      4'd7:    w = nonce_v[63:32];
      4'd8:    w = ctr[31:0];
      4'd9:    w = ctr[63:32];
      4'd10:   w = SIGMA2;
      4'd11:   w = k45[31:0];
      4'd12:   w = k45[63:32];
      4'd13:   w = k67[31:0];
      4'd14:   w = k67[63:32];
      4'd15:   w = SIGMA3;
      default: w = SIGMA0;
    endcase
    return w;
  endfunction

endpackage

### rtl/s20sx_arx.sv
// Shared add-rotate-xor unit: res = c ^ rotl(a + b, rot).
module s20sx_arx import s20sx_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  s20sx_rot_t  rot,
  output logic [31:0] res
);

  logic [31:0] sum;
  logic [31:0] rotated;

  assign sum = a + b;

  always_comb begin
    case (rot)
      ROT_7:   rotated = {sum[24:0], sum[31:25]};
      ROT_9:   rotated = {sum[22:0], sum[31:23]};
      ROT_13:  rotated = {sum[18:0], sum[31:19]};
      ROT_18:  rotated = {sum[13:0], sum[31:14]};
      default: rotated = sum;
    endcase
  end

  assign res = rotated ^ c;

endmodule

### rtl/s20sx_core.sv
// Keystream block generator: 16-word state, sequencer and the shared ARX unit.
`include "salsa20_stream_xor_core_defines.svh"
module s20sx_core import s20sx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        k01,
  input  logic [63:0]        k23,
  input  logic [63:0]        k45,
  input  logic [63:0]        k67,
  input  logic [63:0]        nonce_v,
  input  logic [63:0]        ctr,
  input  logic [4:0]         rounds,
  input  logic [2:0]         word_sel,
  output logic [63:0]        ks_word,
  output s20sx_core_status_t status
);

  s20sx_core_state_t state, state_next;
  logic [3:0]  step, step_next;
  logic [4:0]  rounds_left, rounds_left_next;
  logic [31:0] round_state      [16];
  logic [31:0] round_state_next [16];
  logic [31:0] p_arx            [16];

  logic [1:0]  s, s_prev, s_succ;
  logic [31:0] arx_a, arx_b, arx_c, arx_res;
  s20sx_rot_t  arx_rot;

  // Source index for the end-of-round move: undo the column walk and transpose.
  function automatic logic [3:0] tr_src(input logic [3:0] i);
    return {i[1:0], i[3:2]} + 4'd1;
  endfunction

  assign s      = step[1:0];
  assign s_prev = s - 2'd1;
  assign s_succ = s + 2'd1;

  // The active quarter round always sits at words 0, 4, 8 and 12.
  always_comb begin
    if (state == CORE_FINAL) begin
      arx_a   = round_state[0];
      arx_b   = init_word(step, k01, k23, k45, k67, nonce_v, ctr);
      arx_c   = '0;
      arx_rot = ROT_0;
    end else begin
      arx_a = round_state[{s, 2'b00}];
      arx_b = round_state[{s_prev, 2'b00}];
      arx_c = round_state[{s_succ, 2'b00}];
      case (s)
        2'd0:    arx_rot = ROT_7;
        2'd1:    arx_rot = ROT_9;
        2'd2:    arx_rot = ROT_13;
        2'd3:    arx_rot = ROT_18;
        default: arx_rot = ROT_0;
      endcase
    end
  end

  s20sx_arx u_arx (
    .a   (arx_a),
    .b   (arx_b),
    .c   (arx_c),
    .rot (arx_rot),
    .res (arx_res)
  );

  always_comb begin
    state_next       = state;
    step_next        = step;
    rounds_left_next = rounds_left;
    round_state_next = round_state;
    p_arx            = round_state;
    p_arx[{s_succ, 2'b00}] = arx_res;
    status.busy      = (state != CORE_IDLE);
    status.done      = 1'b0;
    case (state)
      CORE_IDLE: begin
        if (start) begin
          for (int i = 0; i < 16; i++) begin
            round_state_next[i] = init_word(4'(i), k01, k23, k45, k67, nonce_v, ctr);
          end
          rounds_left_next = rounds;
          step_next        = '0;
          state_next       = (rounds == 5'd0) ? CORE_FINAL : CORE_ROUND;
        end
      end
      CORE_ROUND: begin
        step_next = step + 4'd1;
        if (s != 2'd3) begin
          round_state_next = p_arx;
        end else if (step[3:2] != 2'd3) begin
          // advance to the next quarter round: rotate the flat state by five
          for (int i = 0; i < 16; i++) begin
            round_state_next[i] = p_arx[4'(i + 5)];
          end
        end else begin
          for (int i = 0; i < 16; i++) begin
            round_state_next[i] = p_arx[tr_src(4'(i))];
          end
          rounds_left_next = rounds_left - 5'd1;
          if (rounds_left == 5'd1) begin
            state_next = CORE_FINAL;
          end
        end
      end
      CORE_FINAL: begin
        // add the input state back in, one word per cycle, rotating by one
        step_next = step + 4'd1;
        for (int i = 0; i < 15; i++) begin
          round_state_next[i] = round_state[i + 1];
        end
        round_state_next[15] = arx_res;
        if (step == 4'hF) begin
          status.done = 1'b1;
          state_next  = CORE_IDLE;
        end
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CORE_IDLE;
      step        <= '0;
      rounds_left <= '0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      rounds_left <= rounds_left_next;
    end
  end

  always_ff @(posedge clk) begin
    round_state <= round_state_next;
  end

  assign ks_word = {round_state[{word_sel, 1'b1}], round_state[{word_sel, 1'b0}]};

  `S20SX_ASSERT_NXT(a_done_then_idle, status.done, !status.busy, "core busy after done")
  `S20SX_ASSERT_NXT(a_start_busy, start && (state == CORE_IDLE), status.busy,
                    "start did not launch")
  `S20SX_ASSERT_IMP(a_round_left, state == CORE_ROUND, rounds_left != 5'd0,
                    "round state with no rounds left")

endmodule

### rtl/salsa20_stream_xor_core.sv
// Top level of the Salsa20 stream XOR block: config, request control, output register.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid / in_ready       data_word, valid_bytes, last
//   out      result     out_valid / out_ready     out_word, out_last
//   cfg      write      cfg_we                    cfg_index, cfg_data
//
// A request that opens a keystream block (word position zero) is accepted,
// runs the add-rotate-xor steps of the shared unit (16 per round), has the
// input state added back in, then is emitted. Other requests go from
// acceptance straight to emit; the shared ARX unit sets the block time.
// Reset (synchronous, rst high) clears the counter, word position and
// handshakes and restores rounds to 20 with an all-zero key and nonce.
// A stalled result holds in the output register while the next request is
// accepted; that request then waits until the register frees up.
`include "salsa20_stream_xor_core_defines.svh"
module salsa20_stream_xor_core import s20sx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_word,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration registers
  logic [63:0] key_words_0_1, key_words_2_3, key_words_4_5, key_words_6_7;
  logic [63:0] nonce;
  logic [4:0]  rounds;

  // stream position
  logic [63:0] block_counter;
  logic [2:0]  word_position;

  // held request
  logic [63:0] hold_word;
  logic [3:0]  hold_vb;
  logic        hold_last;

  s20sx_top_state_t   state, state_next;
  s20sx_core_status_t core_status;
  logic               core_start;
  logic               load_out;
  logic               accept;
  logic [63:0]        ks_word;

  // Keep byte b when b is below the valid count; counts above 8 keep all.
  function automatic logic [63:0] byte_mask(input logic [3:0] vb);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (4'(b) < vb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_words_0_1 <= '0;
      key_words_2_3 <= '0;
      key_words_4_5 <= '0;
      key_words_6_7 <= '0;
      nonce         <= '0;
      rounds        <= ROUNDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY01:  key_words_0_1 <= cfg_data;
        CFG_KEY23:  key_words_2_3 <= cfg_data;
        CFG_KEY45:  key_words_4_5 <= cfg_data;
        CFG_KEY67:  key_words_6_7 <= cfg_data;
        CFG_NONCE:  nonce         <= cfg_data;
        CFG_ROUNDS: rounds        <= cfg_data[4:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Request control: take a request, generate a block when the position
  // is zero, then emit once the output register is free.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    core_start = 1'b0;
    load_out   = 1'b0;
    case (state)
      TOP_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (word_position == 3'd0) begin
            core_start = 1'b1;
            state_next = TOP_GEN;
          end else begin
            state_next = TOP_EMIT;
          end
        end
      end
      TOP_GEN: begin
        if (core_status.done) begin
          state_next = TOP_EMIT;
        end
      end
      TOP_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = TOP_IDLE;
        end
      end
      default: state_next = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the request payload while the block is generated
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_word <= data_word;
      hold_vb   <= valid_bytes;
      hold_last <= last;
    end
  end

  // Advance the position on emit; a last word sends the stream back to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      word_position <= '0;
    end else if (load_out) begin
      if (hold_last) begin
        block_counter <= '0;
        word_position <= '0;
      end else begin
        word_position <= word_position + 3'd1;
        if (word_position == 3'd7) begin
          block_counter <= block_counter + 64'd1;
        end
      end
    end
  end

  s20sx_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (core_start),
    .k01      (key_words_0_1),
    .k23      (key_words_2_3),
    .k45      (key_words_4_5),
    .k67      (key_words_6_7),
    .nonce_v  (nonce),
    .ctr      (block_counter),
    .rounds   (rounds),
    .word_sel (word_position),
    .ks_word  (ks_word),
    .status   (core_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word <= (hold_word ^ ks_word) & byte_mask(hold_vb);
      out_last <= hold_last;
    end
  end

  `S20SX_ASSERT_IMP(a_done_in_gen, core_status.done, state == TOP_GEN,
                    "core finished outside block generation")
  `S20SX_ASSERT_NXT(a_block_start, accept && (word_position == 3'd0), core_status.busy,
                    "no block generated at word position zero")
  `S20SX_ASSERT_IMP(a_out_from_emit, $rose(out_valid), $past(state) == TOP_EMIT,
                    "result raised outside emit")

endmodule
